// ===== src/atc_pkg.sv =====
// ----------------------------------------------------------------------------
// atc_pkg
// Widths, constants and state codes for the altitude thrust controller.
// ----------------------------------------------------------------------------
package atc_pkg;

    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 24;
    localparam int ERR_W     = 33;
    localparam int TILT_W    = 16;
    localparam int DT_W      = 16;
    localparam int FRAC_W    = 16;
    localparam int INTEG_W   = 18;
    localparam int SUM_W     = 34;
    localparam int INC_W     = 49;
    localparam int ACC_W     = 59;
    localparam int QUO_W     = 58;
    localparam int REM_W     = 16;
    localparam int SCALE_W   = 64;
    localparam int SCALE_PAD = 6;
    localparam int GRAV_W    = 20;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [GRAV_W-1:0]  GRAVITY      = 20'd642908;
    localparam logic [SUM_W-1:0]   INTEG_LIMIT  = 34'd65536;
    localparam logic [GAIN_W-1:0]  RATE_RESET   = 24'd6553600;
    localparam logic [GAIN_W-1:0]  MASS_RESET   = 24'd65536;
    localparam logic [CNT_W-1:0]   MUL_LAST     = CNT_W'(GAIN_W - 1);
    localparam logic [CNT_W-1:0]   DIV_LAST     = CNT_W'(QUO_W - 1);
    localparam logic [DATA_W-1:0]  THRUST_MAX   = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]  THRUST_MIN   = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POSITION_GAIN      = 3'd0,
        REG_VELOCITY_GAIN      = 3'd1,
        REG_INTEGRAL_GAIN      = 3'd2,
        REG_DESCENT_RATE_LIMIT = 3'd3,
        REG_ASCENT_RATE_LIMIT  = 3'd4,
        REG_VEHICLE_MASS       = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_ERR,
        ST_INTEG,
        ST_MUL_INT,
        ST_DIV_SETUP,
        ST_DIVIDE,
        ST_SCALE,
        ST_FINISH
    } state_t;

endpackage

// ===== src/altitude_thrust_control.sv =====
// ----------------------------------------------------------------------------
// altitude_thrust_control
// Vertical PID controller with feed-forward, giving collective thrust.
// ----------------------------------------------------------------------------
// One item is taken while the block is idle; no new item is taken until
// its result has been loaded into the output register and the block is
// idle again. The work is done by the serial datapath: two 24-step
// shift-add passes over the gain bits (errors, then integral), a 58-step
// restoring divide by the tilt cosine one quotient bit per cycle, and a
// 24-step shift-add scaling by vehicle mass. A finished result waits in the
// output register while the next item is accepted.
module altitude_thrust_control (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [atc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [atc_pkg::GAIN_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [atc_pkg::DATA_W-1:0]    height_target,
    input  logic signed [atc_pkg::DATA_W-1:0]    climb_target,
    input  logic signed [atc_pkg::DATA_W-1:0]    height_measured,
    input  logic signed [atc_pkg::DATA_W-1:0]    climb_measured,
    input  logic signed [atc_pkg::DATA_W-1:0]    accel_feedforward,
    input  logic signed [atc_pkg::TILT_W-1:0]    tilt_cosine,
    input  logic [atc_pkg::DT_W-1:0]             time_step,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [atc_pkg::DATA_W-1:0]    thrust_command,
    output logic                                 tilt_fault
);

    atc_pkg::state_t state_reg, state_next;

    logic [atc_pkg::GAIN_W-1:0] pos_gain_reg, vel_gain_reg, int_gain_reg;
    logic [atc_pkg::GAIN_W-1:0] descent_reg, ascent_reg, mass_reg;

    logic signed [atc_pkg::ERR_W-1:0]   pos_err_reg;
    logic signed [atc_pkg::ERR_W-1:0]   vel_tgt_reg;
    logic signed [atc_pkg::DATA_W-1:0]  vel_meas_reg;
    logic signed [atc_pkg::DATA_W-1:0]  ff_reg;
    logic signed [atc_pkg::TILT_W-1:0]  tilt_reg;
    logic [atc_pkg::DT_W-1:0]           dt_sh_reg;
    logic signed [atc_pkg::INTEG_W-1:0] integral_reg;

    logic signed [atc_pkg::ACC_W-1:0]   mpos_reg, mvel_reg;
    logic signed [atc_pkg::ACC_W-1:0]   acc_p_reg, acc_v_reg;
    logic signed [atc_pkg::INC_W-1:0]   acc_i_reg;
    logic [atc_pkg::GAIN_W-1:0]         pg_sh_reg, vg_sh_reg;
    logic [atc_pkg::QUO_W-1:0]          num_sh_reg;
    logic [atc_pkg::REM_W-1:0]          rem_reg;
    logic [atc_pkg::TILT_W-1:0]         div_reg;
    logic                               positive_reg;
    logic [atc_pkg::SCALE_W-1:0]        scale_acc_reg;
    logic [atc_pkg::CNT_W-1:0]          cnt_reg;

    logic                               out_valid_reg, out_valid_next;
    logic signed [atc_pkg::DATA_W-1:0]  thrust_reg;
    logic                               fault_reg;

    logic in_accept, load_out, cnt_mul_done, cnt_div_done;

    // capture
    logic signed [atc_pkg::ERR_W-1:0] vt_ext, descent_ext, ascent_neg, vel_tgt_clamped;
    // datapath
    logic signed [atc_pkg::ERR_W-1:0]   vel_err;
    logic signed [atc_pkg::ACC_W-1:0]   ff_term, grav_term, ffg;
    logic signed [atc_pkg::ERR_W-1:0]   integ_inc;
    logic signed [atc_pkg::SUM_W-1:0]   integ_sum;
    logic signed [atc_pkg::INTEG_W-1:0] integ_clamped;
    logic signed [atc_pkg::ACC_W-1:0]   u_abs;
    logic [atc_pkg::REM_W:0]            trial;
    logic                               qbit;
    logic [atc_pkg::SCALE_W:0]          scale_sum;
    logic                               mag_big;
    logic [atc_pkg::DATA_W-1:0]         mag_low;
    logic [atc_pkg::DATA_W-1:0]         thrust_sat;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_gain_reg <= '0;
            vel_gain_reg <= '0;
            int_gain_reg <= '0;
            descent_reg  <= atc_pkg::RATE_RESET;
            ascent_reg   <= atc_pkg::RATE_RESET;
            mass_reg     <= atc_pkg::MASS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                atc_pkg::REG_POSITION_GAIN:      pos_gain_reg <= cfg_data;
                atc_pkg::REG_VELOCITY_GAIN:      vel_gain_reg <= cfg_data;
                atc_pkg::REG_INTEGRAL_GAIN:      int_gain_reg <= cfg_data;
                atc_pkg::REG_DESCENT_RATE_LIMIT: descent_reg  <= cfg_data;
                atc_pkg::REG_ASCENT_RATE_LIMIT:  ascent_reg   <= cfg_data;
                atc_pkg::REG_VEHICLE_MASS:       mass_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cnt_mul_done = (cnt_reg == atc_pkg::MUL_LAST);
    assign cnt_div_done = (cnt_reg == atc_pkg::DIV_LAST);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            atc_pkg::ST_IDLE:      if (in_valid) state_next = atc_pkg::ST_PREP;
            atc_pkg::ST_PREP:      state_next = atc_pkg::ST_MUL_ERR;
            atc_pkg::ST_MUL_ERR:   if (cnt_mul_done) state_next = atc_pkg::ST_INTEG;
            atc_pkg::ST_INTEG:     state_next = atc_pkg::ST_MUL_INT;
            atc_pkg::ST_MUL_INT:   if (cnt_mul_done) state_next = atc_pkg::ST_DIV_SETUP;
            atc_pkg::ST_DIV_SETUP: state_next = atc_pkg::ST_DIVIDE;
            atc_pkg::ST_DIVIDE:    if (cnt_div_done) state_next = atc_pkg::ST_SCALE;
            atc_pkg::ST_SCALE:     if (cnt_mul_done) state_next = atc_pkg::ST_FINISH;
            atc_pkg::ST_FINISH:    if (!out_valid_reg || out_ready)
                                       state_next = atc_pkg::ST_IDLE;
            default:               state_next = atc_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            atc_pkg::ST_IDLE:   in_ready = 1'b1;
            atc_pkg::ST_FINISH: load_out = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= atc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            case (state_reg)
                atc_pkg::ST_PREP, atc_pkg::ST_INTEG, atc_pkg::ST_DIV_SETUP:
                    cnt_reg <= '0;
                atc_pkg::ST_MUL_ERR, atc_pkg::ST_MUL_INT, atc_pkg::ST_SCALE:
                    cnt_reg <= cnt_reg + 1'b1;
                atc_pkg::ST_DIVIDE:
                    cnt_reg <= cnt_div_done ? '0 : cnt_reg + 1'b1;
                default: ;
            endcase
            if (state_reg == atc_pkg::ST_INTEG)
                integral_reg <= integ_clamped;
        end
    end

    assign out_valid_next = load_out ? 1'b1 : (out_valid_reg && !out_ready);

    // velocity target clamp at capture
    assign vt_ext      = atc_pkg::ERR_W'(climb_target);
    assign descent_ext = $signed(atc_pkg::ERR_W'(descent_reg));
    assign ascent_neg  = -$signed(atc_pkg::ERR_W'(ascent_reg));

    always_comb
    begin
        vel_tgt_clamped = vt_ext;
        if (vt_ext > descent_ext)
            vel_tgt_clamped = descent_ext;
        if (vt_ext < ascent_neg)
            vel_tgt_clamped = ascent_neg;
    end

    assign vel_err   = vel_tgt_reg - atc_pkg::ERR_W'(vel_meas_reg);
    assign ff_term   = atc_pkg::ACC_W'($signed({ff_reg, {atc_pkg::FRAC_W{1'b0}}}));
    assign grav_term = $signed(atc_pkg::ACC_W'({atc_pkg::GRAVITY, {atc_pkg::FRAC_W{1'b0}}}));
    assign ffg       = ff_term - grav_term;

    // integral update, floor of the Q.32 increment
    assign integ_inc = acc_i_reg[atc_pkg::INC_W-1:atc_pkg::FRAC_W];
    assign integ_sum = atc_pkg::SUM_W'(integral_reg) + atc_pkg::SUM_W'(integ_inc);

    always_comb
    begin
        integ_clamped = integ_sum[atc_pkg::INTEG_W-1:0];
        if (integ_sum > $signed(atc_pkg::INTEG_LIMIT))
            integ_clamped = atc_pkg::INTEG_LIMIT[atc_pkg::INTEG_W-1:0];
        if (integ_sum < -$signed(atc_pkg::INTEG_LIMIT))
            integ_clamped = atc_pkg::INTEG_W'(-$signed(atc_pkg::INTEG_LIMIT));
    end

    assign u_abs = acc_p_reg[atc_pkg::ACC_W-1] ? -acc_p_reg : acc_p_reg;

    // restoring divide step
    assign trial = {rem_reg, num_sh_reg[atc_pkg::QUO_W-1]};
    assign qbit  = (trial >= {1'b0, div_reg});

    // mass scaling step, right-shifting accumulator
    assign scale_sum = {1'b0, scale_acc_reg}
                     + (pg_sh_reg[0] ? {1'b0, num_sh_reg, {atc_pkg::SCALE_PAD{1'b0}}}
                                     : '0);

    // saturation
    assign mag_big = |scale_acc_reg[atc_pkg::SCALE_W-1:atc_pkg::DATA_W-1];
    assign mag_low = {1'b0, scale_acc_reg[atc_pkg::DATA_W-2:0]};

    always_comb
    begin
        if (positive_reg)
            thrust_sat = mag_big ? atc_pkg::THRUST_MAX : mag_low;
        else
            thrust_sat = mag_big ? atc_pkg::THRUST_MIN : -mag_low;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            atc_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    pos_err_reg  <= atc_pkg::ERR_W'(height_target)
                                  - atc_pkg::ERR_W'(height_measured);
                    vel_tgt_reg  <= vel_tgt_clamped;
                    vel_meas_reg <= climb_measured;
                    ff_reg       <= accel_feedforward;
                    tilt_reg     <= tilt_cosine;
                    dt_sh_reg    <= time_step;
                end
            end
            atc_pkg::ST_PREP:
            begin
                mpos_reg  <= atc_pkg::ACC_W'(pos_err_reg);
                mvel_reg  <= atc_pkg::ACC_W'(vel_err);
                acc_p_reg <= ffg;
                acc_v_reg <= '0;
                acc_i_reg <= '0;
                pg_sh_reg <= pos_gain_reg;
                vg_sh_reg <= vel_gain_reg;
            end
            atc_pkg::ST_MUL_ERR:
            begin
                acc_p_reg <= acc_p_reg + (pg_sh_reg[0] ? mpos_reg : '0);
                acc_v_reg <= acc_v_reg + (vg_sh_reg[0] ? mvel_reg : '0);
                acc_i_reg <= acc_i_reg
                           + (dt_sh_reg[0] ? mpos_reg[atc_pkg::INC_W-1:0] : '0);
                mpos_reg  <= mpos_reg <<< 1;
                mvel_reg  <= mvel_reg <<< 1;
                pg_sh_reg <= pg_sh_reg >> 1;
                vg_sh_reg <= vg_sh_reg >> 1;
                dt_sh_reg <= dt_sh_reg >> 1;
            end
            atc_pkg::ST_INTEG:
            begin
                acc_p_reg <= acc_p_reg + acc_v_reg;
                mvel_reg  <= atc_pkg::ACC_W'(integ_clamped);
                vg_sh_reg <= int_gain_reg;
            end
            atc_pkg::ST_MUL_INT:
            begin
                acc_p_reg <= acc_p_reg + (vg_sh_reg[0] ? mvel_reg : '0);
                mvel_reg  <= mvel_reg <<< 1;
                vg_sh_reg <= vg_sh_reg >> 1;
            end
            atc_pkg::ST_DIV_SETUP:
            begin
                num_sh_reg   <= u_abs[atc_pkg::QUO_W-1:0];
                div_reg      <= tilt_reg[atc_pkg::TILT_W-1] ? -tilt_reg : tilt_reg;
                positive_reg <= acc_p_reg[atc_pkg::ACC_W-1] != tilt_reg[atc_pkg::TILT_W-1];
                rem_reg      <= '0;
            end
            atc_pkg::ST_DIVIDE:
            begin
                rem_reg    <= qbit ? atc_pkg::REM_W'(trial - {1'b0, div_reg})
                                   : trial[atc_pkg::REM_W-1:0];
                num_sh_reg <= {num_sh_reg[atc_pkg::QUO_W-2:0], qbit};
                if (cnt_div_done)
                begin
                    pg_sh_reg     <= mass_reg;
                    scale_acc_reg <= '0;
                end
            end
            atc_pkg::ST_SCALE:
            begin
                scale_acc_reg <= scale_sum[atc_pkg::SCALE_W:1];
                pg_sh_reg     <= pg_sh_reg >> 1;
            end
            atc_pkg::ST_FINISH:
            begin
                if (load_out)
                begin
                    fault_reg  <= (tilt_reg == '0);
                    thrust_reg <= (tilt_reg == '0) ? '0 : $signed(thrust_sat);
                end
            end
            default: ;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign thrust_command = thrust_reg;
    assign tilt_fault     = fault_reg;

endmodule

// ===== dv/thrust_checker.sv =====
// ----------------------------------------------------------------------------
// thrust_checker
// Predicts and checks the collective thrust of altitude_thrust_control.
// Follows register writes and accepted items, keeps its own altitude error
// integral, computes the expected thrust and tilt fault for every item and
// compares them in order with the results that leave the block.
// ----------------------------------------------------------------------------
module thrust_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [atc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [atc_pkg::GAIN_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic signed [atc_pkg::DATA_W-1:0]    height_target,
    input  logic signed [atc_pkg::DATA_W-1:0]    climb_target,
    input  logic signed [atc_pkg::DATA_W-1:0]    height_measured,
    input  logic signed [atc_pkg::DATA_W-1:0]    climb_measured,
    input  logic signed [atc_pkg::DATA_W-1:0]    accel_feedforward,
    input  logic signed [atc_pkg::TILT_W-1:0]    tilt_cosine,
    input  logic [atc_pkg::DT_W-1:0]             time_step,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [atc_pkg::DATA_W-1:0]    thrust_command,
    input  logic                                 tilt_fault,
    output int                                   fail_count,
    output int                                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [atc_pkg::DATA_W-1:0] thrust;
        logic                       fault;
    } tick_result_t;

    tick_result_t               thrust_expected[$];
    logic [atc_pkg::GAIN_W-1:0] kp;
    logic [atc_pkg::GAIN_W-1:0] kv;
    logic [atc_pkg::GAIN_W-1:0] ki;
    logic [atc_pkg::GAIN_W-1:0] descent_lim;
    logic [atc_pkg::GAIN_W-1:0] ascent_lim;
    logic [atc_pkg::GAIN_W-1:0] mass;
    longint                     integ;

    function automatic tick_result_t predict_thrust(
        input logic signed [atc_pkg::DATA_W-1:0] ht,
        input logic signed [atc_pkg::DATA_W-1:0] ct,
        input logic signed [atc_pkg::DATA_W-1:0] hm,
        input logic signed [atc_pkg::DATA_W-1:0] cm,
        input logic signed [atc_pkg::DATA_W-1:0] af,
        input logic signed [atc_pkg::TILT_W-1:0] tc,
        input logic [atc_pkg::DT_W-1:0]          dt
    );
        longint       climb;
        longint       pos_err;
        longint       vel_err;
        longint       demand;
        logic [63:0]  num;
        logic [63:0]  den;
        logic [63:0]  quo;
        logic [63:0]  hi;
        logic [63:0]  lo;
        logic [63:0]  mag;
        logic         up;
        tick_result_t r;

        climb = longint'(ct);
        if (climb > longint'(descent_lim))
            climb = longint'(descent_lim);
        if (climb < -longint'(ascent_lim))
            climb = -longint'(ascent_lim);

        pos_err = longint'(ht) - longint'(hm);
        vel_err = climb - longint'(cm);

        // floor of the Q.32 increment back to Q16.16, then clamp to +-1.0
        integ = integ + ((pos_err * longint'(dt)) >>> atc_pkg::FRAC_W);
        if (integ > longint'(atc_pkg::INTEG_LIMIT))
            integ = longint'(atc_pkg::INTEG_LIMIT);
        if (integ < -longint'(atc_pkg::INTEG_LIMIT))
            integ = -longint'(atc_pkg::INTEG_LIMIT);

        demand = longint'(kp) * pos_err + longint'(kv) * vel_err + longint'(ki) * integ
               + (longint'(af) <<< atc_pkg::FRAC_W)
               - (longint'(atc_pkg::GRAVITY) <<< atc_pkg::FRAC_W);

        r.thrust = '0;
        r.fault  = 1'b0;
        if (tc == 0)
        begin
            r.fault = 1'b1;
        end
        else if (demand != 0)
        begin
            num = (demand < 0) ? -demand : demand;
            den = (tc < 0) ? -longint'(tc) : longint'(tc);
            up  = (demand < 0) != (tc < 0);
            quo = num / den;
            hi  = (quo >> atc_pkg::GAIN_W) * mass;
            lo  = (quo & 64'hFF_FFFF) * mass;
            if (hi >= (64'd1 << 26))
                mag = 64'd1 << 32;
            else
                mag = (hi << 6) + (lo >> 18);
            if (up)
                r.thrust = (mag > 64'h7FFF_FFFF) ? atc_pkg::THRUST_MAX
                                                 : mag[atc_pkg::DATA_W-1:0];
            else
                r.thrust = (mag > 64'h8000_0000) ? atc_pkg::THRUST_MIN
                                                 : -mag[atc_pkg::DATA_W-1:0];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tick_result_t got;
        tick_result_t want;

        if (!rst_n)
        begin
            kp          = '0;
            kv          = '0;
            ki          = '0;
            descent_lim = atc_pkg::RATE_RESET;
            ascent_lim  = atc_pkg::RATE_RESET;
            mass        = atc_pkg::MASS_RESET;
            integ       = 0;
            thrust_expected.delete();
            pending     = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    atc_pkg::REG_POSITION_GAIN:      kp = cfg_data;
                    atc_pkg::REG_VELOCITY_GAIN:      kv = cfg_data;
                    atc_pkg::REG_INTEGRAL_GAIN:      ki = cfg_data;
                    atc_pkg::REG_DESCENT_RATE_LIMIT: descent_lim = cfg_data;
                    atc_pkg::REG_ASCENT_RATE_LIMIT:  ascent_lim = cfg_data;
                    atc_pkg::REG_VEHICLE_MASS:       mass = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                got.thrust = thrust_command;
                got.fault  = tilt_fault;
                if (thrust_expected.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result: thrust %h fault %b",
                                 $realtime, got.thrust, got.fault);
                    fail_count++;
                end
                else
                begin
                    want = thrust_expected.pop_front();
                    if (got != want)
                    begin
                        if (fail_count < 10)
                            $display("%0t: expected thrust %h fault %b, got thrust %h fault %b",
                                     $realtime, want.thrust, want.fault,
                                     got.thrust, got.fault);
                        fail_count++;
                    end
                end
            end

            if (in_valid && in_ready)
                thrust_expected.push_back(predict_thrust(height_target, climb_target,
                    height_measured, climb_measured, accel_feedforward, tilt_cosine,
                    time_step));

            pending = thrust_expected.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for altitude_thrust_control.
// A directed opening covers hover, zero demand, zero and extreme tilt, climb
// target clamping, integral saturation and thrust saturation; then phases of
// random items run under nominal, full-scale, all-zero and mixed register
// settings, with random idling on both channels except in the last phase.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [atc_pkg::CFG_IDX_W-1:0]     REG_SPARE_A  = 3'd6;
    localparam logic [atc_pkg::CFG_IDX_W-1:0]     REG_SPARE_B  = 3'd7;
    localparam logic signed [atc_pkg::DATA_W-1:0] Q_ONE        = 32'sh0001_0000;
    localparam logic signed [atc_pkg::DATA_W-1:0] Q_MAX        = 32'sh7FFF_FFFF;
    localparam logic signed [atc_pkg::DATA_W-1:0] Q_MIN        = 32'sh8000_0000;
    localparam logic signed [atc_pkg::TILT_W-1:0] TILT_LEVEL   = 16'sd16384;
    localparam logic signed [atc_pkg::TILT_W-1:0] TILT_MAX     = 16'sh7FFF;
    localparam logic signed [atc_pkg::TILT_W-1:0] TILT_MIN     = 16'sh8000;
    localparam logic [atc_pkg::DT_W-1:0]          DT_MAX       = 16'hFFFF;
    localparam logic [atc_pkg::GAIN_W-1:0]        GAIN_MAX     = 24'hFF_FFFF;
    localparam int                                PHASES       = 8;
    localparam int                                PHASE_TICKS  = 210;
    localparam int                                DRAIN_CYCLES = 150;

    typedef enum logic [1:0] {
        SET_NOMINAL,
        SET_FULL,
        SET_ZERO,
        SET_MIXED
    } setting_t;

    logic                              clk               = 1'b0;
    logic                              rst_n             = 1'b0;
    logic                              cfg_write         = 1'b0;
    logic [atc_pkg::CFG_IDX_W-1:0]     cfg_index         = '0;
    logic [atc_pkg::GAIN_W-1:0]        cfg_data          = '0;
    logic                              in_valid          = 1'b0;
    logic                              in_ready;
    logic signed [atc_pkg::DATA_W-1:0] height_target     = '0;
    logic signed [atc_pkg::DATA_W-1:0] climb_target      = '0;
    logic signed [atc_pkg::DATA_W-1:0] height_measured   = '0;
    logic signed [atc_pkg::DATA_W-1:0] climb_measured    = '0;
    logic signed [atc_pkg::DATA_W-1:0] accel_feedforward = '0;
    logic signed [atc_pkg::TILT_W-1:0] tilt_cosine       = '0;
    logic [atc_pkg::DT_W-1:0]          time_step         = '0;
    logic                              out_valid;
    logic                              out_ready         = 1'b1;
    logic signed [atc_pkg::DATA_W-1:0] thrust_command;
    logic                              tilt_fault;
    int                                fail_count;
    int                                pending;
    logic                              calm              = 1'b0;

    altitude_thrust_control i_dut (.*);

    thrust_checker i_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 1) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    function automatic logic [atc_pkg::DATA_W-1:0] rand_q16();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 2))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    default: return '0;
                endcase
            end
            1, 2, 3: return $urandom;
            default: return atc_pkg::DATA_W'($urandom_range(0, 32'h0020_0000))
                            - 32'h0010_0000;
        endcase
    endfunction

    function automatic logic [atc_pkg::TILT_W-1:0] rand_tilt();
        logic [atc_pkg::TILT_W-1:0] mag;

        case ($urandom_range(0, 9))
            0: return '0;
            1: return atc_pkg::TILT_W'($urandom);
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return TILT_MAX;
                    1:       return TILT_MIN;
                    2:       return 16'sd1;
                    default: return -16'sd1;
                endcase
            end
            default:
            begin
                mag = atc_pkg::TILT_W'($urandom_range(8192, 16384));
                return ($urandom_range(0, 7) == 0) ? -mag : mag;
            end
        endcase
    endfunction

    function automatic logic [atc_pkg::DT_W-1:0] rand_dt();
        case ($urandom_range(0, 7))
            0:       return ($urandom_range(0, 1) != 0) ? DT_MAX : '0;
            1:       return atc_pkg::DT_W'($urandom);
            default: return atc_pkg::DT_W'($urandom_range(1, 1400));
        endcase
    endfunction

    function automatic logic [atc_pkg::GAIN_W-1:0] rand_gain(input setting_t s);
        case (s)
            SET_FULL: return GAIN_MAX;
            SET_ZERO: return '0;
            SET_MIXED:
            begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return GAIN_MAX;
                    2:       return atc_pkg::GAIN_W'($urandom);
                    default: return atc_pkg::GAIN_W'($urandom_range(0, 24'h0A_0000));
                endcase
            end
            default: return atc_pkg::GAIN_W'($urandom_range(0, 24'h0A_0000));
        endcase
    endfunction

    task automatic send_tick(
        input logic signed [atc_pkg::DATA_W-1:0] ht,
        input logic signed [atc_pkg::DATA_W-1:0] ct,
        input logic signed [atc_pkg::DATA_W-1:0] hm,
        input logic signed [atc_pkg::DATA_W-1:0] cm,
        input logic signed [atc_pkg::DATA_W-1:0] af,
        input logic signed [atc_pkg::TILT_W-1:0] tc,
        input logic [atc_pkg::DT_W-1:0]          dt
    );
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        height_target     <= ht;
        climb_target      <= ct;
        height_measured   <= hm;
        climb_measured    <= cm;
        accel_feedforward <= af;
        tilt_cosine       <= tc;
        time_step         <= dt;
        in_valid          <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_random_tick();
        send_tick(rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                  rand_tilt(), rand_dt());
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(input logic [atc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [atc_pkg::GAIN_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic apply_setting(input setting_t s);
        put_reg(atc_pkg::REG_POSITION_GAIN, rand_gain(s));
        put_reg(atc_pkg::REG_VELOCITY_GAIN, rand_gain(s));
        put_reg(atc_pkg::REG_INTEGRAL_GAIN, rand_gain(s));
        put_reg(atc_pkg::REG_DESCENT_RATE_LIMIT, rand_gain(s));
        put_reg(atc_pkg::REG_ASCENT_RATE_LIMIT, rand_gain(s));
        put_reg(atc_pkg::REG_VEHICLE_MASS, rand_gain(s));
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        setting_t s;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: hover, zero demand, zero and odd tilts
        send_tick('0, '0, '0, '0, '0, TILT_LEVEL, '0);
        send_tick('0, '0, '0, '0, atc_pkg::DATA_W'(atc_pkg::GRAVITY), TILT_LEVEL, '0);
        send_tick(Q_ONE, '0, '0, '0, '0, '0, 16'd655);
        send_tick('0, '0, '0, '0, '0, -TILT_LEVEL, '0);
        send_tick('0, '0, '0, '0, '0, TILT_MAX, '0);
        send_tick('0, '0, '0, '0, '0, TILT_MIN, '0);
        send_tick('0, '0, '0, '0, '0, 16'sd1, '0);
        send_tick('0, '0, '0, '0, '0, -16'sd1, '0);

        // nominal gains; unused indexes must not disturb them
        wait_idle();
        put_reg(atc_pkg::REG_POSITION_GAIN, 24'h02_0000);
        put_reg(atc_pkg::REG_VELOCITY_GAIN, 24'h01_8000);
        put_reg(atc_pkg::REG_INTEGRAL_GAIN, 24'h00_8000);
        put_reg(atc_pkg::REG_DESCENT_RATE_LIMIT, 24'h05_0000);
        put_reg(atc_pkg::REG_ASCENT_RATE_LIMIT, 24'h03_0000);
        put_reg(atc_pkg::REG_VEHICLE_MASS, 24'h01_8000);
        put_reg(REG_SPARE_A, GAIN_MAX);
        put_reg(REG_SPARE_B, GAIN_MAX);
        cfg_write <= 1'b0;

        send_tick('0, Q_MAX, '0, '0, '0, TILT_LEVEL, 16'd65);
        send_tick('0, Q_MIN, '0, '0, '0, TILT_LEVEL, 16'd65);
        send_tick('0, 32'sh0005_0000, '0, '0, '0, TILT_LEVEL, 16'd65);
        send_tick('0, -32'sh0003_0000, '0, '0, '0, TILT_LEVEL, 16'd65);
        send_tick(Q_MAX, '0, Q_MIN, '0, '0, TILT_LEVEL, DT_MAX);
        send_tick(Q_MAX, '0, Q_MIN, '0, '0, TILT_LEVEL, DT_MAX);
        send_tick(Q_MIN, '0, Q_MAX, '0, '0, TILT_LEVEL, DT_MAX);
        send_tick(Q_MIN, '0, Q_MAX, '0, '0, TILT_LEVEL, DT_MAX);
        send_tick(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, TILT_MAX, DT_MAX);
        send_tick(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, TILT_MIN, '0);

        // full-scale gains and mass: thrust saturation both ways
        wait_idle();
        apply_setting(SET_FULL);
        send_tick('0, '0, '0, '0, '0, 16'sd1, '0);
        send_tick('0, '0, '0, '0, Q_MAX, 16'sd1, '0);
        send_tick(Q_ONE, '0, '0, '0, '0, '0, DT_MAX);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            if (p == 3)
                put_reg(REG_SPARE_A, atc_pkg::GAIN_W'($urandom));
            if (p == 5)
                put_reg(REG_SPARE_B, atc_pkg::GAIN_W'($urandom));
            case (p)
                0, PHASES - 1: s = SET_NOMINAL;
                1:             s = SET_FULL;
                2:             s = SET_ZERO;
                default:       s = SET_MIXED;
            endcase
            apply_setting(s);
            calm = (p == PHASES - 1);
            repeat (PHASE_TICKS) send_random_tick();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
